/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int CNT_W     = $clog2(CELLS + 1);

   // field widths
   localparam int REQ_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int COLOR_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CELL_W    = CHAR_W + ATTR_W;

   // queue depths, powers of two
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // color register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = CSR_IDX_W'(1);

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_ESCAPE  = 8'd27;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [ATTR_W-1:0]  ATTR_RESET = 8'h0F;
   localparam logic [COLOR_W-1:0] FG_RESET   = 4'd15;
   localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;

   typedef enum logic [REQ_W-1:0] {
      REQ_WRITE  = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_READ   = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ
   } cmd_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } eng_state_type;

   typedef enum logic [1:0] {
      SW_INIT,
      SW_CLEAR,
      SW_SCROLL
   } sweep_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [CHAR_W-1:0]   ch;
      logic [ADDR_W-1:0]   addr;
   } cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   cell_char;
      logic [ATTR_W-1:0]   cell_attr;
      logic [ROW_W-1:0]    cursor_row;
      logic [COL_W-1:0]    cursor_col;
      logic                scrolled;
   } rsp_type;

endpackage

/* hw/rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, decodes them into engine commands and queues them.
// ----------------------------------------------------------------------------
module tcw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [tcw_pkg::REQ_W-1:0]    req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]    req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]    req_read_col,
   input  logic                         init_busy,
   output logic                         cmd_valid,
   output tcw_pkg::cmd_type             cmd,
   input  logic                         cmd_pop
);
   import tcw_pkg::*;

   cmd_type                 q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wp_ff, wp_in;
   logic [CMDQ_PTR_W-1:0]   rp_ff, rp_in;
   logic [CMDQ_CNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type                 cmd_new;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    rd_in_range;
   logic                    wr_en;

   assign rd_addr     = ADDR_W'(req_read_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_read_col);
   assign rd_in_range = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLUMNS);

   always_comb begin
      cmd_new.op   = OP_NOP;
      cmd_new.ch   = req_char_code;
      cmd_new.addr = rd_addr;
      unique case (req_kind_type'(req_type))
         REQ_WRITE: begin
            if (req_char_code == CH_NEWLINE) begin
               cmd_new.op = OP_NEWLINE;
            end else if (req_char_code != CH_ESCAPE && req_char_code != CH_NUL) begin
               cmd_new.op = OP_PUT;
            end
         end
         REQ_CLEAR: cmd_new.op = OP_CLEAR;
         // out of range reads answer zeros, same as an unused request
         REQ_READ:  cmd_new.op = rd_in_range ? OP_READ : OP_NOP;
         default:   cmd_new.op = OP_NOP;
      endcase
   end

   assign full      = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH)) || init_busy;
   assign wr_en     = push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wr_en   ? wp_ff + CMDQ_PTR_W'(1) : wp_ff;
      rp_in  = cmd_pop ? rp_ff + CMDQ_PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      unique case ({wr_en, cmd_pop})
         2'b10:   cnt_in = cnt_ff + CMDQ_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CMDQ_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

endmodule

/* hw/rtl/tcw_engine.sv */
// ----------------------------------------------------------------------------
// tcw_engine
// Owns the cursor and the cell store; executes commands and sweeps the store
// for scroll, clear and the fill after reset.
// ----------------------------------------------------------------------------
module tcw_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  tcw_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   input  logic [tcw_pkg::ATTR_W-1:0]   attr,
   input  logic                         rsp_full,
   output logic                         rsp_push,
   output tcw_pkg::rsp_type             rsp,
   output logic                         init_busy
);
   import tcw_pkg::*;

   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]  SW_END    = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0]  SRC_END   = CNT_W'(CELLS - COLUMNS);

   logic [CELL_W-1:0]   mem [CELLS];
   logic [CELL_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   logic [CELL_W-1:0]   mem_wd;
   logic [ADDR_W-1:0]   mem_ra;

   eng_state_type       state_ff, state_in;
   sweep_type           mode_ff, mode_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]    sw_ff, sw_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                pend_blank_ff, pend_blank_in;
   logic [ATTR_W-1:0]   fill_attr_ff, fill_attr_in;
   logic                line_adv;
   logic                done;
   logic [CHAR_W-1:0]   out_char;
   logic [ATTR_W-1:0]   out_attr;
   logic                out_scrolled;

   assign init_busy = (state_ff == ST_SWEEP) && (mode_ff == SW_INIT);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      sw_in         = sw_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_blank_in = pend_blank_ff;
      fill_attr_in  = fill_attr_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = base_ff + ADDR_W'(col_ff);
      mem_wd        = {cmd.ch, attr};
      mem_ra        = cmd.addr;
      line_adv      = 1'b0;
      done          = 1'b0;
      out_char      = '0;
      out_attr      = '0;
      out_scrolled  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_PUT: begin
                     mem_we = 1'b1;
                     if (col_ff == LAST_COL) begin
                        line_adv = 1'b1;
                     end else begin
                        col_in = col_ff + COL_W'(1);
                        done   = 1'b1;
                     end
                  end
                  OP_NEWLINE: line_adv = 1'b1;
                  OP_CLEAR: begin
                     row_in       = '0;
                     col_in       = '0;
                     base_in      = '0;
                     sw_in        = '0;
                     mode_in      = SW_CLEAR;
                     fill_attr_in = attr;
                     state_in     = ST_SWEEP;
                  end
                  OP_READ:  state_in = ST_READ;
                  default:  done = 1'b1;
               endcase
               if (line_adv) begin
                  col_in = '0;
                  if (row_ff == LAST_ROW) begin
                     sw_in        = '0;
                     mode_in      = SW_SCROLL;
                     fill_attr_in = attr;
                     state_in     = ST_SWEEP;
                  end else begin
                     row_in  = row_ff + ROW_W'(1);
                     base_in = base_ff + ADDR_W'(COLUMNS);
                     done    = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            out_char = rd_data_ff[CELL_W-1:ATTR_W];
            out_attr = rd_data_ff[ATTR_W-1:0];
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            // issue stage: fetch the cell one row below for a scroll
            if (sw_ff != SW_END) begin
               mem_ra        = (sw_ff < SRC_END) ?
                               ADDR_W'(sw_ff + CNT_W'(COLUMNS)) : '0;
               pend_in       = 1'b1;
               pend_addr_in  = sw_ff[ADDR_W-1:0];
               pend_blank_in = (mode_ff != SW_SCROLL) || (sw_ff >= SRC_END);
               sw_in         = sw_ff + CNT_W'(1);
            end
            // write stage
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = pend_addr_ff;
               mem_wd = {pend_blank_ff ? CH_SPACE : rd_data_ff[CELL_W-1:ATTR_W],
                         fill_attr_ff};
               if (pend_addr_ff == LAST_ADDR) begin
                  state_in     = ST_IDLE;
                  done         = (mode_ff != SW_INIT);
                  out_scrolled = (mode_ff == SW_SCROLL);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_push       = done;
      rsp.cell_char  = out_char;
      rsp.cell_attr  = out_attr;
      rsp.cursor_row = row_in;
      rsp.cursor_col = col_in;
      rsp.scrolled   = out_scrolled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         mode_ff      <= SW_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         sw_ff        <= '0;
         pend_ff      <= 1'b0;
         fill_attr_ff <= ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         sw_ff        <= sw_in;
         pend_ff      <= pend_in;
         fill_attr_ff <= fill_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= pend_addr_in;
      pend_blank_ff <= pend_blank_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full result queue");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS))
      else $error("cursor outside the screen");

   a_base_tracks_row: assert property (@(posedge clock) disable iff (reset)
      int'(base_ff) == int'(row_ff) * COLUMNS)
      else $error("row base address out of step with cursor row");

   a_read_one_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("cell read did not finish after one wait cycle");

endmodule

/* hw/rtl/tcw_rsp_queue.sv */
// ----------------------------------------------------------------------------
// tcw_rsp_queue
// Small result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module tcw_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_push,
   input  tcw_pkg::rsp_type     rsp_in_data,
   output logic                 rsp_full,
   output logic                 empty,
   input  logic                 pop,
   output tcw_pkg::rsp_type     rsp_out_data
);
   import tcw_pkg::*;

   rsp_type                 q_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]   wp_ff, wp_in;
   logic [RSPQ_PTR_W-1:0]   rp_ff, rp_in;
   logic [RSPQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    rd_en;

   assign rsp_full     = (cnt_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign empty        = (cnt_ff == '0);
   assign rd_en        = pop && !empty;
   assign rsp_out_data = q_ff[rp_ff];

   always_comb begin
      wp_in  = rsp_push ? wp_ff + RSPQ_PTR_W'(1) : wp_ff;
      rp_in  = rd_en    ? rp_ff + RSPQ_PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      unique case ({rsp_push, rd_en})
         2'b10:   cnt_in = cnt_ff + RSPQ_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - RSPQ_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         q_ff[wp_ff] <= rsp_in_data;
      end
   end

endmodule

/* hw/rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console over a rows by columns store of character/attribute cells.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue at up to one per cycle while full
// is low and get one result each, in order, through a two-entry result queue.
// Inside the engine a character write, a newline that does not scroll, an
// ignored character or an unused request finishes in the cycle it is taken; a
// cell read goes through the ST_READ state for the registered memory read. A
// scroll or a clear walks the whole store, one cell per cycle through the
// store's single read and single write port. After reset the store is filled
// with spaces and attribute 0x0F in the same way, with full held high; color
// writes are taken then.
module text_console_writer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [tcw_pkg::REQ_W-1:0]    req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]    req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]    req_read_col,
   output logic                         empty,
   input  logic                         pop,
   output logic [tcw_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]   rsp_cell_attr,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic                         rsp_scrolled,
   input  logic                         csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]  csr_wdata
);
   import tcw_pkg::*;

   logic [COLOR_W-1:0]  fg_ff, fg_in;
   logic [COLOR_W-1:0]  bg_ff, bg_in;
   logic                init_busy;
   logic                cmd_valid;
   cmd_type             cmd;
   logic                cmd_pop;
   logic                rsp_push;
   logic                rsp_full;
   rsp_type             rsp_eng;
   rsp_type             rsp_head;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FOREGROUND: fg_in = csr_wdata;
            CSR_BACKGROUND: bg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   tcw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .init_busy     (init_busy),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   tcw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .attr      ({bg_ff, fg_ff}),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_eng),
      .init_busy (init_busy)
   );

   tcw_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .rsp_push     (rsp_push),
      .rsp_in_data  (rsp_eng),
      .rsp_full     (rsp_full),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_data (rsp_head)
   );

   assign rsp_cell_char  = rsp_head.cell_char;
   assign rsp_cell_attr  = rsp_head.cell_attr;
   assign rsp_cursor_row = rsp_head.cursor_row;
   assign rsp_cursor_col = rsp_head.cursor_col;
   assign rsp_scrolled   = rsp_head.scrolled;

endmodule

/* verif/text_console_checker.sv */
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the request, result and color-register ports of the text console
// writer. It keeps its own copy of the screen, cursor and colors, predicts one
// result per accepted request and compares each popped result field by field.
// ----------------------------------------------------------------------------
module text_console_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             full,
   input  logic [tcw_pkg::REQ_W-1:0]        req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]        req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]        req_read_col,
   input  logic                             empty,
   input  logic                             pop,
   input  logic [tcw_pkg::CHAR_W-1:0]       rsp_cell_char,
   input  logic [tcw_pkg::ATTR_W-1:0]       rsp_cell_attr,
   input  logic [tcw_pkg::ROW_W-1:0]        rsp_cursor_row,
   input  logic [tcw_pkg::COL_W-1:0]        rsp_cursor_col,
   input  logic                             rsp_scrolled,
   input  logic                             csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]      csr_wdata,
   output int unsigned                      error_count,
   output int unsigned                      awaited_count
);
   import tcw_pkg::*;

   logic [CHAR_W-1:0]  glyphs [CELLS];
   logic [ATTR_W-1:0]  tints  [CELLS];
   int                 caret_row;
   int                 caret_col;
   logic [COLOR_W-1:0] fg_color;
   logic [COLOR_W-1:0] bg_color;
   rsp_type            awaited_q [$];

   function automatic logic [ATTR_W-1:0] pen_attr();
      return {bg_color, fg_color};
   endfunction

   function automatic void wipe_screen(input logic [ATTR_W-1:0] attr);
      for (int i = 0; i < CELLS; i++) begin
         glyphs[i] = CH_SPACE;
         tints[i]  = attr;
      end
      caret_row = 0;
      caret_col = 0;
   endfunction

   // column 0 of the next row; past the bottom the text moves up one row
   // and every cell takes the current pen attribute
   function automatic logic line_feed();
      logic [ATTR_W-1:0] attr;
      attr      = pen_attr();
      caret_col = 0;
      caret_row++;
      if (caret_row < ROWS) return 1'b0;
      caret_row = ROWS - 1;
      for (int i = 0; i < CELLS; i++) begin
         if (i < CELLS - COLUMNS) glyphs[i] = glyphs[i + COLUMNS];
         else glyphs[i] = CH_SPACE;
         tints[i] = attr;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type console_step(input req_kind_type kind,
                                            input logic [CHAR_W-1:0] code,
                                            input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
      rsp_type r;
      int      pos;
      r = '0;
      case (kind)
         REQ_WRITE: begin
            if (code == CH_NEWLINE) begin
               r.scrolled = line_feed();
            end else if (code != CH_ESCAPE && code != CH_NUL) begin
               pos         = caret_row * COLUMNS + caret_col;
               glyphs[pos] = code;
               tints[pos]  = pen_attr();
               caret_col++;
               if (caret_col >= COLUMNS) r.scrolled = line_feed();
            end
         end
         REQ_CLEAR: begin
            wipe_screen(pen_attr());
         end
         REQ_READ: begin
            // out of range reads return zero
            if (row < ROWS && col < COLUMNS) begin
               pos         = row * COLUMNS + col;
               r.cell_char = glyphs[pos];
               r.cell_attr = tints[pos];
            end
         end
         default: begin
         end
      endcase
      r.cursor_row = caret_row[ROW_W-1:0];
      r.cursor_col = caret_col[COL_W-1:0];
      return r;
   endfunction

   function automatic void compare_field(input string label, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s: expected %0d, actual %0d", label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wipe_screen(ATTR_RESET);
         fg_color    = FG_RESET;
         bg_color    = BG_RESET;
         error_count = 0;
         awaited_q.delete();
      end else begin
         if (pop && !empty) begin
            if (awaited_q.size() == 0) begin
               error_count++;
               $error("result popped with no request outstanding");
            end else begin
               want = awaited_q.pop_front();
               compare_field("cell_char", want.cell_char, rsp_cell_char);
               compare_field("cell_attr", want.cell_attr, rsp_cell_attr);
               compare_field("cursor_row", want.cursor_row, rsp_cursor_row);
               compare_field("cursor_col", want.cursor_col, rsp_cursor_col);
               compare_field("scrolled", want.scrolled, rsp_scrolled);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_FOREGROUND) fg_color = csr_wdata;
            else if (csr_index == CSR_BACKGROUND) bg_color = csr_wdata;
         end
         if (push && !full)
            awaited_q.push_back(console_step(req_kind_type'(req_type), req_char_code,
                                             req_read_row, req_read_col));
      end
      awaited_count = awaited_q.size();
   end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the text console writer: a short directed sweep of reads,
// writes, ignored bytes, a clear and the unused request type, then three
// random phases of text lines, newlines, reads and noise under different
// colors and idle patterns. Checking is done by text_console_checker.
// ----------------------------------------------------------------------------
module testbench;
   import tcw_pkg::*;

   localparam int     HALF_PERIOD     = 6;
   localparam int     RESET_CYCLES    = 12;
   localparam int     ITEMS_PER_PHASE = 670;
   localparam int     DRAIN_CYCLES    = CELLS + 16;
   // every request a full-store sweep plus long stalls, several times over
   localparam longint TIMEOUT_CYCLES  = 20_000_000;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 push          = 1'b0;
   logic                 full;
   logic [REQ_W-1:0]     req_type      = '0;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [ROW_W-1:0]     req_read_row  = '0;
   logic [COL_W-1:0]     req_read_col  = '0;
   logic                 empty;
   logic                 pop           = 1'b0;
   logic [CHAR_W-1:0]    rsp_cell_char;
   logic [ATTR_W-1:0]    rsp_cell_attr;
   logic [ROW_W-1:0]     rsp_cursor_row;
   logic [COL_W-1:0]     rsp_cursor_col;
   logic                 rsp_scrolled;
   logic                 csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [COLOR_W-1:0]   csr_wdata     = '0;

   int unsigned error_count;
   int unsigned awaited_count;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          meaningful_requests = 0;

   text_console_writer i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .empty          (empty),
      .pop            (pop),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   text_console_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .empty          (empty),
      .pop            (pop),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .awaited_count  (awaited_count)
   );

   always begin
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
   end

   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // called at a falling edge; returns at the falling edge after acceptance
   // with push still high, so back-to-back requests need no gap
   task automatic send_request(input req_kind_type kind, input logic [CHAR_W-1:0] code,
                               input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_type      <= kind;
      req_char_code <= code;
      req_read_row  <= row;
      req_read_col  <= col;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      if (kind != REQ_UNUSED &&
          !(kind == REQ_WRITE && (code == CH_NUL || code == CH_ESCAPE)))
         meaningful_requests++;
   endtask

   task automatic settle_and_set_colors(input logic [COLOR_W-1:0] fg,
                                        input logic [COLOR_W-1:0] bg);
      push <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FOREGROUND;
      csr_wdata <= fg;
      @(negedge clock);
      csr_index <= CSR_BACKGROUND;
      csr_wdata <= bg;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] text_byte();
      if ($urandom_range(19) == 0) return CHAR_W'($urandom_range(255));
      return CHAR_W'($urandom_range(8'h7E, 8'h20));
   endfunction

   task automatic random_traffic(input int budget);
      int               stop_at;
      int               pick;
      int               span;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      stop_at = meaningful_requests + budget;
      while (meaningful_requests < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            // a line of text, now and then long enough to wrap
            span = ($urandom_range(5) == 0) ? $urandom_range(170, 70) : $urandom_range(30);
            repeat (span)
               send_request(REQ_WRITE, text_byte(), ROW_W'($urandom), COL_W'($urandom));
            if ($urandom_range(4) != 0)
               send_request(REQ_WRITE, CH_NEWLINE, ROW_W'($urandom), COL_W'($urandom));
         end else if (pick < 77) begin
            // reads lean toward the bottom rows where fresh text lands
            repeat ($urandom_range(8, 1)) begin
               if ($urandom_range(9) == 0) row = ROW_W'($urandom);
               else if ($urandom_range(1)) row = ROW_W'($urandom_range(ROWS - 1, ROWS - 5));
               else row = ROW_W'($urandom_range(ROWS - 1));
               if ($urandom_range(9) == 0) col = COL_W'($urandom);
               else col = COL_W'($urandom_range(COLUMNS - 1));
               send_request(REQ_READ, CHAR_W'($urandom), row, col);
            end
         end else if (pick < 87) begin
            repeat ($urandom_range(4, 1))
               send_request(REQ_WRITE, CH_NEWLINE, ROW_W'($urandom), COL_W'($urandom));
         end else if (pick < 90) begin
            send_request(REQ_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
         end else if (pick < 95) begin
            // bytes that are dropped, and control bytes that are mostly stored
            case ($urandom_range(2))
               0: send_request(REQ_WRITE, CH_NUL, ROW_W'($urandom), COL_W'($urandom));
               1: send_request(REQ_WRITE, CH_ESCAPE, ROW_W'($urandom), COL_W'($urandom));
               default: send_request(REQ_WRITE, CHAR_W'($urandom_range(31, 1)),
                                     ROW_W'($urandom), COL_W'($urandom));
            endcase
         end else begin
            send_request(req_kind_type'($urandom_range(3)), CHAR_W'($urandom),
                         ROW_W'($urandom), COL_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      // colors can be written while the store is being filled after reset
      settle_and_set_colors(4'd0, 4'd15);

      // untouched store, corners and out of range reads
      send_request(REQ_READ, CH_NUL, '0, '0);
      send_request(REQ_READ, '1, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
      send_request(REQ_READ, CH_NUL, ROW_W'(ROWS), '0);
      send_request(REQ_READ, CH_NUL, '0, COL_W'(COLUMNS));
      send_request(REQ_READ, CH_NUL, '1, '1);
      // printable, dropped and stored control bytes
      send_request(REQ_WRITE, 8'h41, '0, '0);
      send_request(REQ_WRITE, CH_NUL, '1, '1);
      send_request(REQ_WRITE, CH_ESCAPE, '0, '0);
      send_request(REQ_WRITE, 8'hFF, '1, '1);
      send_request(REQ_WRITE, 8'h01, '0, '0);
      send_request(REQ_WRITE, 8'h7F, '0, '0);
      send_request(REQ_READ, CH_NUL, '0, '0);
      send_request(REQ_READ, CH_NUL, '0, COL_W'(1));
      send_request(REQ_READ, CH_NUL, '0, COL_W'(3));
      send_request(REQ_UNUSED, '1, '1, '1);
      send_request(REQ_WRITE, CH_NEWLINE, '0, '0);
      send_request(REQ_WRITE, CH_SPACE, '0, '0);
      send_request(REQ_READ, CH_NUL, ROW_W'(1), '0);
      send_request(REQ_READ, CH_NUL, '0, COL_W'(4));
      // clear paints the pen attribute everywhere and homes the cursor
      send_request(REQ_CLEAR, CH_NUL, '0, '0);
      send_request(REQ_READ, CH_NUL, '0, '0);
      send_request(REQ_READ, CH_NUL, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));

      settle_and_set_colors(4'd15, 4'd15);
      send_idle_pct = 27;
      recv_idle_pct = 64;
      random_traffic(ITEMS_PER_PHASE);

      settle_and_set_colors(4'd0, 4'd0);
      send_idle_pct = 64;
      recv_idle_pct = 27;
      random_traffic(ITEMS_PER_PHASE);

      settle_and_set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(ITEMS_PER_PHASE);

      push <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && awaited_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("testbench: done, errors");
      $finish;
   end

endmodule
